// ===== rtl/core/tnap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnap_pkg
// shared types, sizes and the divide-by-nine digit step for the top-nine pool
// ----------------------------------------------------------------------------
package tnap_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int SUM_GRP    = 3;
	localparam int KEEP_COUNT = SUM_GRP * SUM_GRP;
	localparam int GRP_W      = SAMPLE_W + 2;
	localparam int SUM_W      = SAMPLE_W + 4;
	localparam int MAG_W      = SUM_W - 1;
	localparam int DIVISOR    = KEEP_COUNT;
	localparam int REM_W      = 4;
	localparam int DIGIT_W    = 7;
	localparam int DIV_STG    = MAG_W / DIGIT_W;
	localparam int STG_CNT    = DIV_STG + 5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic ins;
		logic flush;
		logic shift_down;
	} cell_ctl_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] quo;
		logic [REM_W-1:0]   rem;
	} div_step_t;

	// long division of {rem, chunk} by the divisor, one bit per step
	function automatic div_step_t div9_step(input logic [REM_W-1:0] rem,
		input logic [DIGIT_W-1:0] chunk);
		div_step_t        res;
		logic [REM_W-1:0] r;
		logic [REM_W:0]   t;
		r = rem;
		res.quo = '0;
		for (int b = DIGIT_W - 1; b >= 0; b--) begin
			t = {r, chunk[b]};
			if (t >= (REM_W + 1)'(DIVISOR)) begin
				res.quo[b] = 1'b1;
				t = t - (REM_W + 1)'(DIVISOR);
			end
			r = t[REM_W-1:0];
		end
		res.rem = r;
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/top_nine_average_pool.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_nine_average_pool
// average of the nine largest (or smallest) samples of each channel
// ----------------------------------------------------------------------------
//  group  dir  carries
//  s_*    in   tdata: sample Q16.16, tlast: last sample of channel
//  m_*    out  tdata: average Q16.16, tuser: short channel flag
//  cfg_*  in   data: select_largest (1 keeps largest, 0 keeps smallest)
//
// one sample per cycle, while s_tready is high, goes into a row of nine
// sorted cells, which take an insertion in each such cycle; the last sample
// of a channel also hands the store to a 10-stage sum and divide pipe.
// s_tready drops only when that pipe is full and m_tready holds it back.
// after reset the store is empty and select_largest is 1; no clearing pass.
// ----------------------------------------------------------------------------
module top_nine_average_pool (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] sample
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] average
	output logic        m_tuser,   // [0] short_channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data
);
	import tnap_pkg::*;

	logic      sel_largest_q;
	logic      accept;
	cell_ctl_t ctl;
	sample_t   sample;

	sample_t              cell_val   [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] cell_valid;
	logic [KEEP_COUNT-1:0] cell_g;
	logic [KEEP_COUNT-1:0] cell_lt;
	sample_t              nxt_val    [KEEP_COUNT];
	logic [KEEP_COUNT-1:0] nxt_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_largest_q <= 1'b1;
		end else if (cfg_valid) begin
			sel_largest_q <= cfg_data;
		end
	end

	assign sample         = s_tdata;
	assign accept         = s_tvalid && s_tready;
	assign ctl.ins        = accept;
	assign ctl.flush      = accept && s_tlast;
	assign ctl.shift_down = cell_valid[KEEP_COUNT-1] && sel_largest_q;

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		sample_t lv;
		logic    lg;
		logic    lval;
		sample_t rv;
		logic    rlt;

		if (i == 0) begin : g_first
			assign lv   = sample;
			assign lg   = 1'b0;
			assign lval = 1'b1;
		end else begin : g_mid_lo
			assign lv   = cell_val[i-1];
			assign lg   = cell_g[i-1];
			assign lval = cell_valid[i-1];
		end

		if (i == KEEP_COUNT - 1) begin : g_last
			assign rv  = sample;
			assign rlt = 1'b0;
		end else begin : g_mid_hi
			assign rv  = cell_val[i+1];
			assign rlt = cell_lt[i+1];
		end

		tnap_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sample     (sample),
			.left_val   (lv),
			.left_g     (lg),
			.left_valid (lval),
			.right_val  (rv),
			.right_lt   (rlt),
			.val        (cell_val[i]),
			.valid      (cell_valid[i]),
			.g          (cell_g[i]),
			.lt         (cell_lt[i]),
			.nxt_val    (nxt_val[i]),
			.nxt_valid  (nxt_valid[i])
		);
	end

	sample_t avg;

	tnap_avg u_avg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (ctl.flush),
		.in_ready      (s_tready),
		.in_vals       (nxt_val),
		.in_short      (!nxt_valid[KEEP_COUNT-1]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.average       (avg),
		.short_channel (m_tuser)
	);

	assign m_tdata = avg;

`ifndef NO_ASSERTIONS
	// the last word of a channel empties the store
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> cell_valid == '0)
		else $error("store not cleared after last word");

	// filled slots always form a run from the bottom
	assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + KEEP_COUNT'(1)) & cell_valid) == '0)
		else $error("store fill pattern has a hole");

	// a full store keeps its ends in order
	assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[KEEP_COUNT-1] |-> cell_val[0] <= cell_val[KEEP_COUNT-1])
		else $error("store out of order");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tnap_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnap_cell
// one slot of the sorted store; shifts toward either neighbor on insertion
// ----------------------------------------------------------------------------
module tnap_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  tnap_pkg::cell_ctl_t    ctl,
	input  tnap_pkg::sample_t      sample,
	input  tnap_pkg::sample_t      left_val,
	input  wire                    left_g,
	input  wire                    left_valid,
	input  tnap_pkg::sample_t      right_val,
	input  wire                    right_lt,
	output tnap_pkg::sample_t      val,
	output logic                   valid,
	output logic                   g,
	output logic                   lt,
	output tnap_pkg::sample_t      nxt_val,
	output logic                   nxt_valid
);
	import tnap_pkg::*;

	sample_t val_q;
	logic    valid_q;
	sample_t nxt_raw;

	// empty slots rank above everything so the fill position falls out of g
	assign g  = !valid_q || (val_q > sample);
	assign lt = val_q < sample;

	always_comb begin
		if (ctl.shift_down) begin
			// drop the lowest entry, slide down and place the sample
			if (right_lt) begin
				nxt_raw = right_val;
			end else if (lt) begin
				nxt_raw = sample;
			end else begin
				nxt_raw = val_q;
			end
		end else begin
			// open a gap and slide the upper part up (top drops off when full)
			if (left_g) begin
				nxt_raw = left_val;
			end else if (g) begin
				nxt_raw = sample;
			end else begin
				nxt_raw = val_q;
			end
		end
	end

	assign nxt_valid = valid_q || left_valid;
	assign nxt_val   = nxt_valid ? nxt_raw : '0;
	assign val       = val_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			valid_q <= ctl.flush ? 1'b0 : nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			val_q <= nxt_raw;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tnap_avg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnap_avg
// pipelined sum of the kept slots and truncating divide by nine
// ----------------------------------------------------------------------------
module tnap_avg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  tnap_pkg::sample_t      in_vals [tnap_pkg::KEEP_COUNT],
	input  wire                    in_short,
	output logic                   out_valid,
	input  wire                    out_ready,
	output tnap_pkg::sample_t      average,
	output logic                   short_channel
);
	import tnap_pkg::*;

	logic [STG_CNT-1:0] vld_q;
	logic [STG_CNT-1:0] rdy;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		rdy[STG_CNT-1] = !vld_q[STG_CNT-1] || out_ready;
		for (int k = STG_CNT - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STG_CNT; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: snapshot of the store
	sample_t val_s1 [KEEP_COUNT];
	logic    short_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			val_s1   <= in_vals;
			short_s1 <= in_short;
		end
	end

	// stage 2: partial sums of three
	logic signed [GRP_W-1:0] sum3_s2 [SUM_GRP];
	logic                    short_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int j = 0; j < SUM_GRP; j++) begin
				sum3_s2[j] <= GRP_W'(val_s1[SUM_GRP*j]) + GRP_W'(val_s1[SUM_GRP*j+1])
					+ GRP_W'(val_s1[SUM_GRP*j+2]);
			end
			short_s2 <= short_s1;
		end
	end

	// stage 3: total
	logic signed [SUM_W-1:0] total_s3;
	logic                    short_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			total_s3 <= SUM_W'(sum3_s2[0]) + SUM_W'(sum3_s2[1]) + SUM_W'(sum3_s2[2]);
			short_s3 <= short_s2;
		end
	end

	// stage 4: sign and magnitude
	logic [SUM_W-1:0] total_neg;
	logic [MAG_W-1:0] mag_s4;
	logic             neg_s4;
	logic             short_s4;

	assign total_neg = -total_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			neg_s4   <= total_s3[SUM_W-1];
			mag_s4   <= total_s3[SUM_W-1] ? total_neg[MAG_W-1:0] : total_s3[MAG_W-1:0];
			short_s4 <= short_s3;
		end
	end

	// division stages, one digit of the quotient each, index 0 is the stage 4 output
	logic [MAG_W-1:0] mag_s   [DIV_STG+1];
	logic [MAG_W-1:0] quo_s   [DIV_STG+1];
	logic [REM_W-1:0] rem_s   [DIV_STG+1];
	logic             neg_s   [DIV_STG+1];
	logic             short_s [DIV_STG+1];

	assign mag_s[0]   = mag_s4;
	assign quo_s[0]   = '0;
	assign rem_s[0]   = '0;
	assign neg_s[0]   = neg_s4;
	assign short_s[0] = short_s4;

	for (genvar d = 0; d < DIV_STG; d++) begin : g_div
		localparam int HI = MAG_W - 1 - DIGIT_W * d;
		div_step_t        step;
		logic [MAG_W-1:0] quo_nxt;

		assign step = div9_step(rem_s[d], mag_s[d][HI -: DIGIT_W]);

		always_comb begin
			quo_nxt = quo_s[d];
			quo_nxt[HI -: DIGIT_W] = step.quo;
		end

		always_ff @(posedge clk) begin
			if (rdy[4+d]) begin
				mag_s[d+1]   <= mag_s[d];
				quo_s[d+1]   <= quo_nxt;
				rem_s[d+1]   <= step.rem;
				neg_s[d+1]   <= neg_s[d];
				short_s[d+1] <= short_s[d];
			end
		end
	end

	// output stage: restore the sign, truncation is toward zero
	logic [SAMPLE_W-1:0] quo_lo;
	sample_t             avg_q;
	logic                short_q;

	assign quo_lo = quo_s[DIV_STG][SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy[STG_CNT-1]) begin
			avg_q   <= neg_s[DIV_STG] ? -quo_lo : quo_lo;
			short_q <= short_s[DIV_STG];
		end
	end

	assign out_valid     = vld_q[STG_CNT-1];
	assign average       = avg_q;
	assign short_channel = short_q;

endmodule
`default_nettype wire

// ===== tb/tnap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnap_checker
// watches the sample, result and mode channels of top_nine_average_pool,
// keeps its own model of the kept samples per channel, and
// compares every result word with the oldest predicted average
// ----------------------------------------------------------------------------
module tnap_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] sample
	input  wire         s_tlast,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,   // [31:0] average
	input  wire         m_tuser,   // [0] short_channel
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire         cfg_data,
	output int          errors,
	output int          awaiting
);
	import tnap_pkg::*;

	typedef struct {
		sample_t average;
		logic    short_channel;
	} pool_result_t;

	sample_t      kept[KEEP_COUNT];
	int unsigned  filled = 0;
	bit           keep_largest = 1'b1;
	pool_result_t predicted_averages[$];

	initial begin
		errors = 0;
		awaiting = 0;
		foreach (kept[i]) kept[i] = '0;
	end

	function automatic bit ranks_above(input sample_t a, input sample_t b);
		return keep_largest ? (a > b) : (a < b);
	endfunction

	// insert one word into the store; a channel end yields the expected average
	task automatic absorb_sample(input sample_t value, input bit last);
		int unsigned  worst;
		longint       total;
		pool_result_t res;
		if (filled < KEEP_COUNT) begin
			kept[filled] = value;
			filled++;
		end else begin
			worst = 0;
			for (int i = 1; i < KEEP_COUNT; i++)
				if (ranks_above(kept[worst], kept[i])) worst = i;
			// equal to the worst kept value is not better, store unchanged
			if (ranks_above(value, kept[worst])) kept[worst] = value;
		end
		if (last) begin
			total = 0;
			for (int i = 0; i < filled; i++) total += longint'(kept[i]);
			// signed division truncates toward zero; empty slots count as zero
			res.average = sample_t'(total / KEEP_COUNT);
			res.short_channel = (filled < KEEP_COUNT);
			predicted_averages.push_back(res);
			filled = 0;
			foreach (kept[i]) kept[i] = '0;
		end
	endtask

	task automatic compare_result(input sample_t average, input logic short_channel);
		pool_result_t want;
		if (predicted_averages.size() == 0) begin
			$error("unexpected result word: average %0d short_channel %0b",
				average, short_channel);
			errors++;
		end else begin
			want = predicted_averages.pop_front();
			if (average !== want.average) begin
				$error("average: expected %0d, actual %0d", want.average, average);
				errors++;
			end
			if (short_channel !== want.short_channel) begin
				$error("short_channel: expected %0b, actual %0b",
					want.short_channel, short_channel);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) keep_largest = cfg_data;
			if (s_tvalid && s_tready) absorb_sample(sample_t'(s_tdata), s_tlast);
			if (m_tvalid && m_tready) compare_result(sample_t'(m_tdata), m_tuser);
			awaiting = predicted_averages.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives channels of Q16.16 samples into top_nine_average_pool under both
// keep modes, with random gaps and result back-pressure; tnap_checker
// predicts and compares every average
// ----------------------------------------------------------------------------
module tb;
	import tnap_pkg::*;

	localparam bit KEEP_LARGEST  = 1'b1;
	localparam bit KEEP_SMALLEST = 1'b0;
	localparam int DRAIN_CYCLES  = 16;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	int          errors;
	int          awaiting;
	bit          src_steady = 1'b0;
	bit          sink_steady = 1'b0;

	top_nine_average_pool DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tnap_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .awaiting(awaiting)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("top_nine_average_pool regression: fail");
		$finish;
	end

	// result side: random stalls per word, with runs of no stalls
	initial begin : result_sink
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
			hold = sink_steady ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic push_sample(input sample_t value, input bit last);
		int unsigned gap;
		if ($urandom_range(0, 19) == 0) src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// let the block drain fully, then write the keep mode
	task automatic write_mode(input bit largest);
		@(negedge clk) s_tvalid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= largest;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 9))
			5, 6: begin
				case ($urandom_range(0, 4))
					0: return sample_t'(32'h8000_0000);
					1: return sample_t'(32'h7FFF_FFFF);
					2: return sample_t'(0);
					3: return sample_t'(-1);
					default: return sample_t'(1);
				endcase
			end
			// narrow range makes ties against the worst kept value common
			7, 8: return sample_t'(int'($urandom_range(0, 7)) - 4);
			9: return sample_t'(int'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic int unsigned channel_length();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, KEEP_COUNT - 1);
			8, 9: return $urandom_range(KEEP_COUNT + 8, 40);
			default: return $urandom_range(KEEP_COUNT, KEEP_COUNT + 7);
		endcase
	endfunction

	initial begin : stimulus
		int unsigned sent;
		int unsigned span;
		bit          mode;
		@(posedge arst_n);
		write_mode(KEEP_LARGEST);

		// single-word channel at the top of the range
		push_sample(sample_t'(32'h7FFF_FFFF), 1'b1);
		// full store of the most negative value, a tie, then a better word
		repeat (KEEP_COUNT + 1) push_sample(sample_t'(32'h8000_0000), 1'b0);
		push_sample(sample_t'(5), 1'b1);
		// mode flips to smallest with three words already kept
		push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		write_mode(KEEP_SMALLEST);
		repeat (3) push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
		push_sample(sample_t'(32'h8000_0000), 1'b0);
		push_sample(sample_t'(1), 1'b0);
		repeat (2) push_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
		push_sample(sample_t'(-2), 1'b1);

		mode = $urandom_range(0, 1);
		for (int phase = 0; phase < PHASES; phase++) begin
			mode = !mode;
			write_mode(mode ? KEEP_LARGEST : KEEP_SMALLEST);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				span = channel_length();
				for (int k = 0; k < span; k++) push_sample(draw_sample(), k == span - 1);
				sent += span;
			end
			// sometimes leave a channel open across the mode change
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 12)) push_sample(draw_sample(), 1'b0);
		end
		push_sample(draw_sample(), 1'b1);

		@(negedge clk) s_tvalid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && awaiting == 0)
			$display("top_nine_average_pool regression: pass");
		else
			$display("top_nine_average_pool regression: fail");
		$finish;
	end

endmodule
